// File: sv/rbc_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer commit package
// Shared types and command, op and status codes.
// ----------------------------------------------------------------------------
package rbc_pkg;

   localparam logic [1:0] CMD_PUSH     = 2'd0;
   localparam logic [1:0] CMD_COMPLETE = 2'd1;
   localparam logic [1:0] CMD_COMMIT   = 2'd2;
   localparam logic [1:0] CMD_NONE     = 2'd3;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_LOAD = 3'd4;
   localparam logic [2:0] OP_JUMP = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BAD_OP   = 2'd2;
   localparam logic [1:0] ST_BAD_SLOT = 2'd3;

   localparam int REQ_BITS = 82;
   localparam int RSP_BITS = 84;

   typedef struct packed {
      logic signed [31:0] done_value;
      logic [3:0]         entry_index;
      logic signed [31:0] predicted_value;
      logic [3:0]         station_tag;
      logic [4:0]         dest_reg;
      logic [2:0]         op;
      logic [1:0]         cmd;
   } req_type;

   typedef struct packed {
      logic               running;
      logic signed [31:0] new_pc;
      logic               flush;
      logic [3:0]         clear_tag;
      logic               clear_enable;
      logic signed [31:0] wb_value;
      logic [4:0]         wb_reg;
      logic               wb_enable;
      logic               retired;
      logic [3:0]         alloc_entry;
      logic [1:0]         status;
   } rsp_type;

endpackage

// File: sv/rbc_queue.sv
// ----------------------------------------------------------------------------
// Reorder buffer command queue
// Two-entry queue between the front end and the execute stage.
// ----------------------------------------------------------------------------
module rbc_queue import rbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_data
);
   req_type   slot_ff [2];
   logic      rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] count_ff, count_in;
   logic      push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      rd_in = pop ? ~rd_ff : rd_ff;
      wr_in = push ? ~wr_ff : wr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> count_ff == 2'd2)
      else $error("queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> !out_valid)
      else $error("queue shows data when empty");
endmodule

// File: sv/rbc_exec.sv
// ----------------------------------------------------------------------------
// Reorder buffer execute stage
// Holds the ring and does push, complete and commit, one command a cycle unless stalled.
// ----------------------------------------------------------------------------
module rbc_exec import rbc_pkg::*; #(
   parameter int PcIndex = 31
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   localparam int Depth = 16;

   logic [2:0]  op_mem   [Depth];
   logic [4:0]  dest_mem [Depth];
   logic [3:0]  tag_mem  [Depth];
   logic [31:0] res_mem  [Depth];
   logic [31:0] pred_mem [Depth];
   logic [Depth-1:0] ready_ff, ready_in;
   logic [3:0]  head_ff, head_in, tail_ff, tail_in;
   logic [4:0]  occ_ff, occ_in;
   logic        valid_ff, valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        take, do_push, do_complete, in_range;
   logic [3:0]  slot_offset, h, ring_span;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;
   assign take = in_valid && in_ready;
   assign h = head_ff;
   assign slot_offset = in_data.entry_index - head_ff;
   assign ring_span = tail_ff - head_ff;
   assign in_range = ({1'b0, slot_offset} < occ_ff);
   assign do_push = take && in_data.cmd == CMD_PUSH && occ_ff != 5'(Depth);
   assign do_complete = take && in_data.cmd == CMD_COMPLETE && in_range;

   always_comb begin
      ready_in = ready_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      rsp_in   = '0;
      rsp_in.running = 1'b1;
      valid_in = take ? 1'b1 : (valid_ff && !out_ready);
      case (in_data.cmd)
         CMD_PUSH: begin
            if (!do_push) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.alloc_entry = tail_ff;
               ready_in[tail_ff] = 1'b0;
               tail_in = tail_ff + 4'd1;
               occ_in = occ_ff + 5'd1;
            end
         end
         CMD_COMPLETE: begin
            if (!in_range) begin
               rsp_in.status = ST_BAD_SLOT;
            end else begin
               ready_in[in_data.entry_index] = 1'b1;
            end
         end
         CMD_COMMIT: begin
            if (occ_ff != 5'd0 && ready_ff[h]) begin
               rsp_in.retired = 1'b1;
               ready_in[h] = 1'b0;
               head_in = h + 4'd1;
               occ_in = occ_ff - 5'd1;
               if (op_mem[h] <= OP_LOAD) begin
                  rsp_in.wb_enable = 1'b1;
                  rsp_in.wb_reg = dest_mem[h];
                  rsp_in.wb_value = res_mem[h];
                  rsp_in.clear_enable = 1'b1;
                  rsp_in.clear_tag = tag_mem[h];
               end else if (op_mem[h] == OP_JUMP) begin
                  if (res_mem[h] != pred_mem[h]) begin
                     rsp_in.flush = 1'b1;
                     rsp_in.new_pc = res_mem[h];
                     rsp_in.wb_reg = 5'(PcIndex);
                     rsp_in.running = 1'b0;
                     ready_in = '0;
                     head_in = tail_ff;
                     occ_in = 5'd0;
                  end else begin
                     rsp_in.wb_reg = dest_mem[h];
                     rsp_in.clear_enable = 1'b1;
                     rsp_in.clear_tag = tag_mem[h];
                  end
               end else begin
                  rsp_in.status = ST_BAD_OP;
                  rsp_in.running = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      if (!take) begin
         ready_in = ready_ff;
         head_in  = head_ff;
         tail_in  = tail_ff;
         occ_in   = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         ready_ff <= ready_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
         valid_ff <= valid_in;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
      if (do_push) begin
         op_mem[tail_ff]   <= in_data.op;
         dest_mem[tail_ff] <= in_data.dest_reg;
         tag_mem[tail_ff]  <= in_data.station_tag;
         pred_mem[tail_ff] <= in_data.predicted_value;
         res_mem[tail_ff]  <= '1;
      end else if (do_complete) begin
         res_mem[in_data.entry_index] <= in_data.done_value;
      end
   end

   assert property (@(posedge clock) disable iff (reset) occ_ff <= 5'(Depth))
      else $error("occupancy above depth");
   assert property (@(posedge clock) disable iff (reset)
      (occ_ff != 5'(Depth)) |-> ({1'b0, ring_span} == occ_ff))
      else $error("pointers disagree with occupancy");
   assert property (@(posedge clock) disable iff (reset)
      (take && rsp_in.flush) |=> occ_ff == 5'd0 && ready_ff == '0)
      else $error("flush left entries");
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> valid_ff)
      else $error("result dropped");
endmodule

// File: sv/reorder_buffer_commit_top.sv
// ----------------------------------------------------------------------------
// Reorder buffer commit top level
// In-order 16-entry reorder buffer with push, complete and commit commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// req       in         tvalid/tready      command item, cmd on tuser
// rsp       out        tvalid/tready      one result item per command
//
// A command passes a two-entry queue and is then executed into the result
// register, so the block sustains one item per cycle with no stalls.
// Throughput falls below one item per cycle only while rsp_tready is low.
// Reset is synchronous and empties the buffer, queue and result register.
// A stalled rsp side fills the queue, then deasserts req_tready.
module reorder_buffer_commit_top import rbc_pkg::*; #(
   parameter int PC_INDEX = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd
   input  logic [1:0]  req_tuser,
   // op, dest_reg, station_tag, predicted_value, entry_index, done_value
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, alloc_entry, retired, wb_enable, wb_reg, wb_value, clear_enable,
   // clear_tag, flush, new_pc, running
   output logic [87:0] rsp_tdata
);
   req_type q_data;
   rsp_type r_data;
   logic    q_valid, q_ready;

   rbc_queue u_queue (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_type'({req_tdata, req_tuser})),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   rbc_exec #(.PcIndex(PC_INDEX)) u_exec (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(r_data)
   );

   assign rsp_tdata = {4'd0, r_data};
endmodule

// File: test/reorder_buffer_commit_checker.sv
// ----------------------------------------------------------------------------
// Reorder buffer commit checker
// Watches both channels, keeps a predictor of the buffer contents, and
// compares every result item field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module reorder_buffer_commit_checker import rbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [79:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int EXP_DEPTH = 64;
   localparam logic [4:0] PC_REG = 5'd31;

   logic [2:0]  slot_op [DEPTH];
   logic [4:0]  slot_dest [DEPTH];
   logic [3:0]  slot_tag [DEPTH];
   logic        slot_ready [DEPTH];
   logic [31:0] slot_result [DEPTH];
   logic [31:0] slot_target [DEPTH];
   logic [3:0]  head;
   logic [3:0]  tail;
   int          fill;
   rsp_type     exp_mem [EXP_DEPTH];
   int          exp_wr;
   int          exp_rd;

   assign pending_count = exp_wr - exp_rd;

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic rsp_type predict_rob(input req_type r);
      rsp_type o;
      logic [3:0] offset;
      o = '0;
      o.running = 1'b1;
      case (r.cmd)
         CMD_PUSH: begin
            if (fill >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               slot_op[tail] = r.op;
               slot_dest[tail] = r.dest_reg;
               slot_tag[tail] = r.station_tag;
               slot_target[tail] = r.predicted_value;
               slot_ready[tail] = 1'b0;
               slot_result[tail] = 32'hFFFF_FFFF;
               o.alloc_entry = tail;
               tail = tail + 4'd1;
               fill++;
            end
         end
         CMD_COMPLETE: begin
            offset = r.entry_index - head;
            if (int'(offset) >= fill) begin
               o.status = ST_BAD_SLOT;
            end else begin
               slot_result[r.entry_index] = r.done_value;
               slot_ready[r.entry_index] = 1'b1;
            end
         end
         CMD_COMMIT: begin
            if (fill != 0 && slot_ready[head]) begin
               o.retired = 1'b1;
               slot_ready[head] = 1'b0;
               fill--;
               if (slot_op[head] <= OP_LOAD) begin
                  o.wb_enable = 1'b1;
                  o.wb_reg = slot_dest[head];
                  o.wb_value = slot_result[head];
                  o.clear_enable = 1'b1;
                  o.clear_tag = slot_tag[head];
               end else if (slot_op[head] == OP_JUMP) begin
                  if (slot_result[head] != slot_target[head]) begin
                     o.flush = 1'b1;
                     o.new_pc = slot_result[head];
                     o.wb_reg = PC_REG;
                     o.running = 1'b0;
                     for (int i = 0; i < DEPTH; i++) slot_ready[i] = 1'b0;
                     fill = 0;
                  end else begin
                     o.wb_reg = slot_dest[head];
                     o.clear_enable = 1'b1;
                     o.clear_tag = slot_tag[head];
                  end
               end else begin
                  o.status = ST_BAD_OP;
                  o.running = 1'b0;
               end
               head = (o.flush) ? tail : head + 4'd1;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         head = '0;
         tail = '0;
         fill = 0;
         for (int i = 0; i < DEPTH; i++) slot_ready[i] = 1'b0;
         exp_wr = 0;
         exp_rd = 0;
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            exp_mem[exp_wr % EXP_DEPTH] = predict_rob(req_type'({req_tdata, req_tuser}));
            exp_wr++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[RSP_BITS-1:0]);
            if (exp_wr == exp_rd) begin
               report("unexpected item", 0, 0);
            end else begin
               want = exp_mem[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (got.status != want.status) report("status", got.status, want.status);
               if (got.alloc_entry != want.alloc_entry)
                  report("alloc_entry", got.alloc_entry, want.alloc_entry);
               if (got.retired != want.retired) report("retired", got.retired, want.retired);
               if (got.wb_enable != want.wb_enable)
                  report("wb_enable", got.wb_enable, want.wb_enable);
               if (got.wb_reg != want.wb_reg) report("wb_reg", got.wb_reg, want.wb_reg);
               if (got.wb_value != want.wb_value)
                  report("wb_value", got.wb_value, want.wb_value);
               if (got.clear_enable != want.clear_enable)
                  report("clear_enable", got.clear_enable, want.clear_enable);
               if (got.clear_tag != want.clear_tag)
                  report("clear_tag", got.clear_tag, want.clear_tag);
               if (got.flush != want.flush) report("flush", got.flush, want.flush);
               if (got.new_pc != want.new_pc) report("new_pc", got.new_pc, want.new_pc);
               if (got.running != want.running) report("running", got.running, want.running);
            end
         end
      end
   end

endmodule

// File: test/reorder_buffer_commit_top_tb.sv
// ----------------------------------------------------------------------------
// Reorder buffer commit testbench
// Drives directed and random push, complete and commit sequences with random
// gaps and stalls; the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module reorder_buffer_commit_top_tb import rbc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   int          idle_cycles;
   bit          steady;
   bit          stim_done;
   int          shadow_fill;
   logic [3:0]  shadow_head;
   logic [3:0]  shadow_tail;

   reorder_buffer_commit_top DUT (.*);

   reorder_buffer_commit_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit gap_now();
      return !steady && ($urandom_range(99) < 36);
   endfunction

   task automatic send_item(input req_type r);
      while (gap_now()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser <= r.cmd;
      req_tdata <= {r.done_value, r.entry_index, r.predicted_value, r.station_tag,
                    r.dest_reg, r.op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Tracks the ring roughly so random completes mostly hit live slots.
   task automatic send_cmd(input logic [1:0] cmd, input logic [2:0] op,
                           input logic [3:0] idx, input logic [31:0] a,
                           input logic [31:0] b);
      req_type r;
      r.cmd = cmd;
      r.op = op;
      r.dest_reg = 5'($urandom);
      r.station_tag = 4'($urandom);
      r.predicted_value = a;
      r.entry_index = idx;
      r.done_value = b;
      if (cmd == CMD_PUSH && shadow_fill < 16) begin
         shadow_tail++;
         shadow_fill++;
      end
      send_item(r);
   endtask

   task automatic push_commit_all();
      logic [3:0] i;
      i = shadow_head;
      repeat (shadow_fill) begin
         send_cmd(CMD_COMPLETE, OP_ADD, i, 0, $urandom);
         i++;
      end
      repeat (shadow_fill + 1) send_cmd(CMD_COMMIT, OP_ADD, 0, 0, 0);
   endtask

   initial begin
      int k;
      logic [31:0] v;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      reset = 1'b1;
      steady = 1'b0;
      stim_done = 1'b0;
      shadow_fill = 0;
      shadow_head = '0;
      shadow_tail = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_cmd(CMD_COMMIT, OP_ADD, 0, 0, 0);
      send_cmd(CMD_COMPLETE, OP_ADD, 4'd15, 0, 32'h7FFF_FFFF);
      for (int o = 0; o < 8; o++)
         send_cmd(CMD_PUSH, 3'(o), 0, (o == 5) ? 32'h8000_0000 : $urandom, 0);
      send_cmd(CMD_COMMIT, OP_ADD, 0, 0, 0);
      send_cmd(CMD_COMPLETE, OP_ADD, 4'd0, 0, 32'h8000_0000);
      send_cmd(CMD_COMPLETE, OP_ADD, 4'd0, 0, 32'h7FFF_FFFF);
      send_cmd(CMD_COMMIT, OP_ADD, 0, 0, 0);
      send_cmd(CMD_COMPLETE, OP_ADD, 4'd9, 0, 0);
      send_cmd(CMD_NONE, OP_ADD, 0, 0, 0);
      for (int o = 0; o < 9; o++) send_cmd(CMD_PUSH, OP_ADD, 0, 0, 0);
      send_cmd(CMD_PUSH, OP_ADD, 0, 0, 0);
      // Head is slot 1 with 16 entries; retire until a flush or an empty buffer.
      for (k = 1; k < 16; k++) send_cmd(CMD_COMPLETE, OP_ADD, 4'(k), 0, 32'h8000_0000);
      send_cmd(CMD_COMPLETE, OP_ADD, 4'd0, 0, $urandom);
      repeat (17) send_cmd(CMD_COMMIT, OP_ADD, 0, 0, 0);

      // Jump entries with a wrong target end a run by flushing,
      // so the random part resynchronizes by draining fully now and then.
      for (k = 0; k < 200; k++) begin
         steady = (k >= 70 && k < 110);
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               v = $urandom;
               send_cmd(CMD_PUSH, ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                        : 3'($urandom_range(5)), 0, v, 0);
            end
            4, 5, 6: send_cmd(CMD_COMPLETE, OP_ADD,
                              ($urandom_range(9) == 0) ? 4'($urandom)
                              : shadow_head + 4'($urandom_range(shadow_fill > 0 ?
                                                                 shadow_fill - 1 : 0)),
                              0, ($urandom_range(1)) ? 32'h8000_0000 : $urandom);
            default: send_cmd(CMD_COMMIT, OP_ADD, 0, 0, 0);
         endcase
         if ($urandom_range(29) == 0) begin
            push_commit_all();
            // Unknown state after drains: resync by flushing with a jump.
            send_cmd(CMD_PUSH, OP_JUMP, 0, 32'd1, 0);
            send_cmd(CMD_COMPLETE, OP_ADD, 0, 0, 0);
            for (int j = 0; j < 16; j++) send_cmd(CMD_COMPLETE, OP_ADD, 4'(j), 0, 32'd2);
            repeat (17) send_cmd(CMD_COMMIT, OP_ADD, 0, 0, 0);
            shadow_fill = 0;
            shadow_head = shadow_tail;
         end
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_tready <= !gap_now();
         @(negedge clock);
      end
   end

   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (stim_done && pending_count == 0) begin
            repeat (10) @(posedge clock);
            if (fail_count == 0 && pending_count == 0) $display("simulation ok");
            else $display("simulation failed");
            $finish;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule

// File: filelist.f
sv/rbc_pkg.sv
sv/rbc_queue.sv
sv/rbc_exec.sv
sv/reorder_buffer_commit_top.sv
test/reorder_buffer_commit_checker.sv
test/reorder_buffer_commit_top_tb.sv
